/* src/tdcm_pkg.sv */
// ============================================================================
// tdcm_pkg - shared types and constants of the table DFA character matcher
// Field widths, function and result codes, queue sizes and the table address
// helper used by the front, the queue and the back part.
// ============================================================================
package tdcm_pkg;

  // Field widths
  localparam int STATE_W    = 8;
  localparam int CHAR_W     = 7;
  localparam int FUNC_W     = 2;
  localparam int KIND_W     = 2;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int FLG_W      = 2;

  // Automaton size
  localparam int MAX_STATES    = 256;
  localparam int ALPHABET_SIZE = 96;
  localparam int CHAR_BASE     = 32;
  localparam int CHAR_END      = CHAR_BASE + ALPHABET_SIZE;

  localparam int TBL_DEPTH = MAX_STATES * ALPHABET_SIZE;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int FLG_AW    = $clog2(MAX_STATES);

  localparam logic [STATE_W:0] STATE_LIMIT = (STATE_W + 1)'(MAX_STATES);
  localparam logic [CHAR_W:0]  CHAR_LO     = (CHAR_W + 1)'(CHAR_BASE);
  localparam logic [CHAR_W:0]  CHAR_HI     = (CHAR_W + 1)'(CHAR_END);

  // Input functions (also the command op codes after classification)
  localparam logic [FUNC_W-1:0] FUNC_TRANS = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FLAGS = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MATCH = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_MCHAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MEND    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd2;

  // Match modes
  localparam logic [MODE_W-1:0] MODE_FULL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ALL  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd1;

  // Command queue and result buffer
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);
  localparam int RES_DEPTH = 8;
  localparam int RES_AW    = $clog2(RES_DEPTH);
  localparam int RES_CW    = $clog2(RES_DEPTH + 1);
  localparam int CRED_W    = RES_CW + 1;

  // Classified command
  typedef struct packed {
    logic [FUNC_W-1:0]  op;
    logic [STATE_W-1:0] idx;
    logic [CHAR_W-1:0]  chr;
    logic [CHAR_W-1:0]  off;
    logic               chr_ok;
    logic [STATE_W-1:0] nxt;
    logic               fin;
    logic               dead;
    logic               eos;
  } cmd_t;

  // Front to queue
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_push_t;

  // Queue head to back
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } q_head_t;

  // One result beat
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] chr;
    logic              verdict;
    logic              last;
  } res_t;

  function automatic logic state_in_range(input logic [STATE_W-1:0] st);
    return {1'b0, st} < STATE_LIMIT;
  endfunction

  function automatic logic [TBL_AW-1:0] tbl_addr(input logic [STATE_W-1:0] st,
                                                 input logic [CHAR_W-1:0]  off);
    return TBL_AW'(st) * TBL_AW'(ALPHABET_SIZE) + TBL_AW'(off);
  endfunction

endpackage

/* src/tdcm_if.sv */
// ============================================================================
// tdcm_if - channel interfaces of the table DFA character matcher
// Input item channel, result channel and configuration write channel, each
// a valid/ready channel with source, sink and monitor views.
// ============================================================================
interface tdcm_in_if;
  logic                         valid;
  logic                         ready;
  logic [tdcm_pkg::FUNC_W-1:0]  func;
  logic [tdcm_pkg::STATE_W-1:0] state_index;
  logic [tdcm_pkg::CHAR_W-1:0]  char_code;
  logic [tdcm_pkg::STATE_W-1:0] next_state;
  logic                         final_flag;
  logic                         dead_flag;
  logic                         end_of_string;

  modport source (output valid, func, state_index, char_code, next_state,
                  final_flag, dead_flag, end_of_string, input ready);
  modport sink   (input valid, func, state_index, char_code, next_state,
                  final_flag, dead_flag, end_of_string, output ready);
  modport mon    (input valid, ready, func, state_index, char_code, next_state,
                  final_flag, dead_flag, end_of_string);
endinterface

interface tdcm_out_if;
  logic                        valid;
  logic                        ready;
  logic [tdcm_pkg::KIND_W-1:0] kind;
  logic [tdcm_pkg::CHAR_W-1:0] out_char;
  logic                        verdict;
  logic                        last_result;

  modport source (output valid, kind, out_char, verdict, last_result, input ready);
  modport sink   (input valid, kind, out_char, verdict, last_result, output ready);
  modport mon    (input valid, ready, kind, out_char, verdict, last_result);
endinterface

interface tdcm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tdcm_pkg::CFG_IDX_W-1:0]  index;
  logic [tdcm_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

/* src/table_dfa_char_matcher_unit.sv */
// ============================================================================
// table_dfa_char_matcher_unit - table-driven DFA character matcher
// Loads fill a transition table and a state flag table; match beats feed a
// string one character at a time and produce verdicts or match marks.
// ============================================================================
//
//  Channel | Dir | Beat carries                                   | Accepted when
//  --------+-----+------------------------------------------------+--------------
//  in_ch   | in  | func, state_index, char_code, next_state,      | valid & ready
//          |     | final_flag, dead_flag, end_of_string           |
//  out_ch  | out | kind, out_char, verdict, last_result           | valid & ready
//  cfg_ch  | in  | index (0 start_state, 1 match_mode), data      | valid & ready
//
//  Flow: one beat a cycle in while the queue has room; a result passes the
//  lookup and decision stages into the result buffer. A match-all character
//  waits for the previous flags; other beats issue one a cycle unless stalled.
//  Reset: synchronous, active low; 256 valid flops make the flag table read
//  as zero, the transition table is undefined until written.
//  Stalls: 4-entry queue, 8-entry result buffer; a character needs room for two.
//
module table_dfa_char_matcher_unit (
  input logic        clk,
  input logic        rst_n,
  tdcm_in_if.sink    in_ch,
  tdcm_out_if.source out_ch,
  tdcm_cfg_if.sink   cfg_ch
);

  tdcm_pkg::q_push_t q_push;
  tdcm_pkg::q_head_t q_head;
  logic              q_full;
  logic              q_pop;

  // Front: classify input beats, drop those that change nothing
  tdcm_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push)
  );

  // Queue: hold classified commands while the back is busy
  tdcm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .head  (q_head),
    .pop   (q_pop)
  );

  // Back: run the automaton and buffer the results
  tdcm_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

endmodule

/* src/tdcm_ram.sv */
// ============================================================================
// tdcm_ram - generic simple dual-port RAM
// One write port, one read port with registered read data; a read of the
// address being written returns the old contents.
// ============================================================================
module tdcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/tdcm_front.sv */
// ============================================================================
// tdcm_front - input classifier
// Decode the function of each input beat, check state and character ranges,
// drop items that have no effect and push the rest into the command queue.
// ============================================================================
module tdcm_front (
  tdcm_in_if.sink          in_ch,
  input  logic             q_full,
  output tdcm_pkg::q_push_t push
);

  tdcm_pkg::cmd_t cmd;
  logic           idx_ok;
  logic           nxt_ok;
  logic           keep;

  assign in_ch.ready = !q_full;

  always_comb begin
    cmd        = '0;
    cmd.op     = in_ch.func;
    cmd.idx    = in_ch.state_index;
    cmd.chr    = in_ch.char_code;
    cmd.off    = in_ch.char_code - tdcm_pkg::CHAR_W'(tdcm_pkg::CHAR_BASE);
    cmd.chr_ok = ({1'b0, in_ch.char_code} >= tdcm_pkg::CHAR_LO) &&
                 ({1'b0, in_ch.char_code} <  tdcm_pkg::CHAR_HI);
    cmd.nxt    = in_ch.next_state;
    cmd.fin    = in_ch.final_flag;
    cmd.dead   = in_ch.dead_flag;
    cmd.eos    = in_ch.end_of_string;

    idx_ok = tdcm_pkg::state_in_range(in_ch.state_index);
    nxt_ok = tdcm_pkg::state_in_range(in_ch.next_state);

    // drop unused functions and loads that point outside the tables
    case (in_ch.func)
      tdcm_pkg::FUNC_TRANS: keep = idx_ok && nxt_ok && cmd.chr_ok;
      tdcm_pkg::FUNC_FLAGS: keep = idx_ok;
      tdcm_pkg::FUNC_MATCH: keep = 1'b1;
      default:              keep = 1'b0;
    endcase
  end

  assign push.vld = in_ch.valid && in_ch.ready && keep;
  assign push.cmd = cmd;

endmodule

/* src/tdcm_queue.sv */
// ============================================================================
// tdcm_queue - command queue between front and back
// Small FIFO of classified commands; lets the front keep accepting while
// the back waits on the result buffer.
// ============================================================================
module tdcm_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  tdcm_pkg::q_push_t push,
  output logic              full,
  output tdcm_pkg::q_head_t head,
  input  logic              pop
);

  tdcm_pkg::cmd_t                ent_r [tdcm_pkg::Q_DEPTH];
  logic [tdcm_pkg::Q_AW-1:0]     wptr_r;
  logic [tdcm_pkg::Q_AW-1:0]     rptr_r;
  logic [tdcm_pkg::Q_CW-1:0]     cnt_r;
  logic [tdcm_pkg::Q_CW-1:0]     cnt_nxt;
  logic                          do_pop;

  assign full     = (cnt_r == tdcm_pkg::Q_CW'(tdcm_pkg::Q_DEPTH));
  assign head.vld = (cnt_r != '0);
  assign head.cmd = ent_r[rptr_r];
  assign do_pop   = pop && head.vld;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.vld && !do_pop) begin
      cnt_nxt = cnt_r + tdcm_pkg::Q_CW'(1);
    end else if (!push.vld && do_pop) begin
      cnt_nxt = cnt_r - tdcm_pkg::Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld) begin
      ent_r[wptr_r] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.vld) begin
        wptr_r <= wptr_r + tdcm_pkg::Q_AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + tdcm_pkg::Q_AW'(1);
      end
    end
  end

endmodule

/* src/tdcm_back.sv */
// ============================================================================
// tdcm_back - automaton execution pipeline
// Issue loads and table lookups, read the flags of the reached state, keep
// the string state, and queue up to two results per character for output.
// ============================================================================
module tdcm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  tdcm_pkg::q_head_t head,
  output logic              pop,
  tdcm_cfg_if.sink          cfg_ch,
  tdcm_out_if.source        out_ch
);

  // configuration
  logic [tdcm_pkg::STATE_W-1:0] start_r;
  logic [tdcm_pkg::MODE_W-1:0]  mode_r;
  logic                         cfg_we;
  logic                         cfg_restart;
  logic                         mode_all;
  logic                         mode_pre;

  // string state
  logic [tdcm_pkg::STATE_W-1:0] cur_r;
  logic [tdcm_pkg::STATE_W-1:0] cur_nxt;
  logic                         open_r;
  logic                         open_nxt;
  logic                         rej_r;
  logic                         rej_nxt;

  // issue stage
  logic                         head_match;
  logic [tdcm_pkg::STATE_W-1:0] s1_cur;
  logic                         s1_ok;
  logic                         credit_ok;
  logic                         issue;
  logic                         tbl_we;
  logic                         tbl_re;
  logic [tdcm_pkg::TBL_AW-1:0]  tbl_waddr;
  logic [tdcm_pkg::TBL_AW-1:0]  tbl_raddr;
  logic [tdcm_pkg::STATE_W-1:0] tbl_rdata;
  logic                         flg_we;
  logic [tdcm_pkg::FLG_W-1:0]   flg_rdata;
  logic [tdcm_pkg::MAX_STATES-1:0] flg_vld_r;

  // lookup stage
  logic                         s2_vld_r;
  logic                         s2_ok_r;
  logic [tdcm_pkg::STATE_W-1:0] s2_cur_r;
  logic [tdcm_pkg::CHAR_W-1:0]  s2_chr_r;
  logic                         s2_eos_r;
  logic [tdcm_pkg::STATE_W-1:0] s2_next;
  logic                         flg_re;

  // decision stage
  logic                         s3_vld_r;
  logic                         s3_ok_r;
  logic [tdcm_pkg::STATE_W-1:0] s3_ns_r;
  logic [tdcm_pkg::CHAR_W-1:0]  s3_chr_r;
  logic                         s3_eos_r;
  logic                         s3_fv_r;
  logic                         fin;
  logic                         dead;
  logic [tdcm_pkg::STATE_W-1:0] s3_next;
  tdcm_pkg::res_t               e0;
  tdcm_pkg::res_t               e1;
  logic                         e0_v;
  logic                         e1_v;
  tdcm_pkg::res_t               first;
  tdcm_pkg::res_t               second;
  logic [1:0]                   push_n;

  // result buffer
  tdcm_pkg::res_t               res_r [tdcm_pkg::RES_DEPTH];
  logic [tdcm_pkg::RES_AW-1:0]  res_wptr_r;
  logic [tdcm_pkg::RES_AW-1:0]  res_rptr_r;
  logic [tdcm_pkg::RES_CW-1:0]  res_cnt_r;
  logic                         out_pop;
  tdcm_pkg::res_t               out_res;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;
  assign cfg_restart  = cfg_we && ((cfg_ch.index == tdcm_pkg::CFG_START) ||
                                   (cfg_ch.index == tdcm_pkg::CFG_MODE));
  assign mode_all     = (mode_r == tdcm_pkg::MODE_ALL);
  assign mode_pre     = (mode_r == tdcm_pkg::MODE_PRE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      mode_r  <= tdcm_pkg::MODE_FULL;
    end else if (cfg_we) begin
      case (cfg_ch.index)
        tdcm_pkg::CFG_START: start_r <= cfg_ch.data[tdcm_pkg::STATE_W-1:0];
        tdcm_pkg::CFG_MODE:  mode_r  <= cfg_ch.data[tdcm_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Issue: loads write the tables, characters start the table lookup
  // --------------------------------------------------------------------------
  assign s2_next = s2_eos_r ? start_r : (s2_ok_r ? tbl_rdata : s2_cur_r);

  // take the current state from the youngest item that has settled it
  always_comb begin
    if (s2_vld_r && !mode_all) begin
      s1_cur = s2_next;
    end else if (s3_vld_r && mode_all) begin
      s1_cur = s3_next;
    end else begin
      s1_cur = cur_r;
    end
  end

  assign head_match = head.vld && (head.cmd.op == tdcm_pkg::FUNC_MATCH);
  assign s1_ok      = head.cmd.chr_ok && tdcm_pkg::state_in_range(s1_cur);
  assign credit_ok  = (tdcm_pkg::CRED_W'(res_cnt_r) +
                       tdcm_pkg::CRED_W'({s2_vld_r, 1'b0}) +
                       tdcm_pkg::CRED_W'({s3_vld_r, 1'b0}) +
                       tdcm_pkg::CRED_W'(2)) <=
                      tdcm_pkg::CRED_W'(tdcm_pkg::RES_DEPTH);
  // in match-all mode the next lookup waits for the flags of the last one
  assign issue      = head.vld &&
                      (!head_match || (credit_ok && !(mode_all && s2_vld_r)));
  assign pop        = issue;

  assign tbl_we    = issue && (head.cmd.op == tdcm_pkg::FUNC_TRANS);
  assign tbl_waddr = tdcm_pkg::tbl_addr(head.cmd.idx, head.cmd.off);
  assign tbl_re    = issue && head_match && s1_ok;
  assign tbl_raddr = tdcm_pkg::tbl_addr(s1_cur, head.cmd.off);
  assign flg_we    = issue && (head.cmd.op == tdcm_pkg::FUNC_FLAGS);

  tdcm_ram #(
    .WIDTH (tdcm_pkg::STATE_W),
    .DEPTH (tdcm_pkg::TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (head.cmd.nxt),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  tdcm_ram #(
    .WIDTH (tdcm_pkg::FLG_W),
    .DEPTH (tdcm_pkg::MAX_STATES)
  ) u_flg_ram (
    .clk   (clk),
    .we    (flg_we),
    .waddr (head.cmd.idx[tdcm_pkg::FLG_AW-1:0]),
    .wdata ({head.cmd.dead, head.cmd.fin}),
    .re    (flg_re),
    .raddr (tbl_rdata[tdcm_pkg::FLG_AW-1:0]),
    .rdata (flg_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_vld_r <= '0;
    end else if (flg_we) begin
      flg_vld_r[head.cmd.idx[tdcm_pkg::FLG_AW-1:0]] <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Lookup: next state arrives, read its flags
  // --------------------------------------------------------------------------
  assign flg_re = s2_vld_r && s2_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= issue && head_match;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_ok_r  <= s1_ok;
    s2_cur_r <= s1_cur;
    s2_chr_r <= head.cmd.chr;
    s2_eos_r <= head.cmd.eos;
    s3_ok_r  <= s2_ok_r;
    s3_ns_r  <= tbl_rdata;
    s3_chr_r <= s2_chr_r;
    s3_eos_r <= s2_eos_r;
    s3_fv_r  <= flg_vld_r[tbl_rdata[tdcm_pkg::FLG_AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Decision: results and string state
  // --------------------------------------------------------------------------
  assign fin  = s3_fv_r && flg_rdata[0];
  assign dead = s3_fv_r && flg_rdata[1];

  assign s3_next = s3_eos_r ? start_r :
                   ((s3_ok_r && (fin || !dead)) ? s3_ns_r : start_r);

  always_comb begin
    open_nxt = open_r;
    rej_nxt  = rej_r;
    e0_v     = 1'b0;
    e1_v     = 1'b0;
    e0       = '0;
    e1       = '0;
    if (s3_vld_r) begin
      if (mode_all) begin
        if (s3_ok_r && fin) begin
          e0_v     = 1'b1;
          e0.kind  = tdcm_pkg::KIND_MCHAR;
          e0.chr   = s3_chr_r;
          open_nxt = 1'b1;
        end else if (!s3_ok_r || dead) begin
          if (open_r) begin
            e0_v    = 1'b1;
            e0.kind = tdcm_pkg::KIND_MEND;
          end
          open_nxt = 1'b0;
        end
        if (s3_eos_r && open_nxt) begin
          e1_v    = 1'b1;
          e1.kind = tdcm_pkg::KIND_MEND;
        end
      end else if (mode_pre) begin
        if (!rej_r) begin
          if (!s3_ok_r || dead) begin
            e0_v    = 1'b1;
            e0.kind = tdcm_pkg::KIND_VERDICT;
            rej_nxt = 1'b1;
          end else if (s3_eos_r) begin
            e0_v       = 1'b1;
            e0.kind    = tdcm_pkg::KIND_VERDICT;
            e0.verdict = fin;
          end
        end
      end else begin
        if (!rej_r && !s3_ok_r) begin
          rej_nxt = 1'b1;
        end
        if (s3_eos_r) begin
          e0_v       = 1'b1;
          e0.kind    = tdcm_pkg::KIND_VERDICT;
          e0.verdict = !rej_nxt && fin;
        end
      end
      if (s3_eos_r) begin
        open_nxt = 1'b0;
        rej_nxt  = 1'b0;
      end
    end
    if (cfg_restart) begin
      open_nxt = 1'b0;
      rej_nxt  = 1'b0;
    end
  end

  // a start-state write restarts from the new value, a mode write from the old
  function automatic logic [tdcm_pkg::STATE_W-1:0] start_nxt_val();
    return (cfg_ch.index == tdcm_pkg::CFG_START) ?
           cfg_ch.data[tdcm_pkg::STATE_W-1:0] : start_r;
  endfunction

  always_comb begin
    if (cfg_restart) begin
      cur_nxt = start_nxt_val();
    end else if (s2_vld_r && !mode_all) begin
      cur_nxt = s2_next;
    end else if (s3_vld_r && mode_all) begin
      cur_nxt = s3_next;
    end else begin
      cur_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      open_r <= 1'b0;
      rej_r  <= 1'b0;
    end else begin
      cur_r  <= cur_nxt;
      open_r <= open_nxt;
      rej_r  <= rej_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: pack one or two results, mark the last of the item
  // --------------------------------------------------------------------------
  always_comb begin
    first       = e0_v ? e0 : e1;
    first.last  = !(e0_v && e1_v);
    second      = e1;
    second.last = 1'b1;
    push_n      = {1'b0, e0_v} + {1'b0, e1_v};
  end

  assign out_res            = res_r[res_rptr_r];
  assign out_ch.valid       = (res_cnt_r != '0);
  assign out_ch.kind        = out_res.kind;
  assign out_ch.out_char    = out_res.chr;
  assign out_ch.verdict     = out_res.verdict;
  assign out_ch.last_result = out_res.last;
  assign out_pop            = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      res_r[res_wptr_r] <= first;
    end
    if (push_n == 2'd2) begin
      res_r[res_wptr_r + tdcm_pkg::RES_AW'(1)] <= second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wptr_r <= '0;
      res_rptr_r <= '0;
      res_cnt_r  <= '0;
    end else begin
      res_wptr_r <= res_wptr_r + tdcm_pkg::RES_AW'(push_n);
      res_cnt_r  <= res_cnt_r + tdcm_pkg::RES_CW'(push_n) -
                    tdcm_pkg::RES_CW'(out_pop);
      if (out_pop) begin
        res_rptr_r <= res_rptr_r + tdcm_pkg::RES_AW'(1);
      end
    end
  end

endmodule

/* src/tdcm_chk.sv */
// ============================================================================
// tdcm_chk - port checker of the table DFA character matcher
// Watches the result channel and flags beats that the block must never show.
// ============================================================================
module tdcm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tdcm_pkg::KIND_W-1:0] out_kind,
  input logic [tdcm_pkg::CHAR_W-1:0] out_char,
  input logic                        out_verdict,
  input logic                        out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_kind) && $stable(out_char) &&
      $stable(out_verdict) && $stable(out_last))
    else $error("result beat changed while stalled");

  // only a matched character can be followed by another result of its item
  a_not_last_is_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_kind == tdcm_pkg::KIND_MCHAR)
    else $error("non-final result of an item is not a matched character");

  // verdict bit and character are zero where the kind does not use them
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_kind == tdcm_pkg::KIND_VERDICT || out_verdict == 1'b0) &&
      (out_kind == tdcm_pkg::KIND_MCHAR || out_char == '0))
    else $error("unused result field not zero");

  // reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind table_dfa_char_matcher_unit tdcm_chk u_tdcm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .out_char    (out_ch.out_char),
  .out_verdict (out_ch.verdict),
  .out_last    (out_ch.last_result)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_top - testbench of the table DFA character matcher
// Fills a small automaton (four reachable states, four alphabet characters),
// runs a directed set in each match mode, then random strings, loads and
// noise through several register settings and idle/stall phases. Every
// accepted input beat is predicted in-bench; every result beat is checked
// field by field against the oldest predicted result.
// ============================================================================
module tb_top;

  // Unused function code and the mode alias that behaves as full match
  localparam logic [tdcm_pkg::FUNC_W-1:0] FUNC_NOP        = 2'd3;
  localparam logic [tdcm_pkg::MODE_W-1:0] MODE_FULL_ALIAS = 2'd3;

  localparam int RESET_CYCLES    = 12;
  localparam int SETTLE_CYCLES   = 16;   // queue depth plus pipeline, with margin
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int BEATS_PER_PHASE = 45;
  localparam int RANDOM_PHASES   = 9;

  typedef struct packed {
    logic [tdcm_pkg::FUNC_W-1:0]  func;
    logic [tdcm_pkg::STATE_W-1:0] state_index;
    logic [tdcm_pkg::CHAR_W-1:0]  char_code;
    logic [tdcm_pkg::STATE_W-1:0] next_state;
    logic                         final_flag;
    logic                         dead_flag;
    logic                         end_of_string;
  } in_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tdcm_in_if  in_ch ();
  tdcm_out_if out_ch ();
  tdcm_cfg_if cfg_ch ();

  table_dfa_char_matcher_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Bench-side drive variables; known from time zero
  logic                            drv_valid = 1'b0;
  in_beat_t                        drv_beat  = '0;
  logic                            res_ready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [tdcm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tdcm_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  assign in_ch.valid         = drv_valid;
  assign in_ch.func          = drv_beat.func;
  assign in_ch.state_index   = drv_beat.state_index;
  assign in_ch.char_code     = drv_beat.char_code;
  assign in_ch.next_state    = drv_beat.next_state;
  assign in_ch.final_flag    = drv_beat.final_flag;
  assign in_ch.dead_flag     = drv_beat.dead_flag;
  assign in_ch.end_of_string = drv_beat.end_of_string;
  assign out_ch.ready        = res_ready;
  assign cfg_ch.valid        = cfg_valid;
  assign cfg_ch.index        = cfg_index;
  assign cfg_ch.data         = cfg_data;

  // Clock: 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Automaton shadow: tables, registers and string state
  // --------------------------------------------------------------------------
  logic [tdcm_pkg::STATE_W-1:0] dfa_next [0:tdcm_pkg::TBL_DEPTH-1];
  logic [tdcm_pkg::FLG_W-1:0]   dfa_flags [0:tdcm_pkg::MAX_STATES-1]; // bit 0 final, 1 dead
  logic [tdcm_pkg::STATE_W-1:0] shadow_cur   = '0;
  logic                         dfa_open     = 1'b0;
  logic                         dfa_rejected = 1'b0;
  logic [tdcm_pkg::STATE_W-1:0] reg_start    = '0;
  logic [tdcm_pkg::MODE_W-1:0]  reg_mode     = tdcm_pkg::MODE_FULL;

  tdcm_pkg::res_t expected_results [$];
  in_beat_t       pending_beats [$];
  int             beats_queued   = 0;
  int             mismatches     = 0;
  int             results_seen   = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;

  logic hold_req  = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;

  function automatic tdcm_pkg::res_t make_res(logic [tdcm_pkg::KIND_W-1:0] k,
                                              logic [tdcm_pkg::CHAR_W-1:0] c,
                                              logic v);
    tdcm_pkg::res_t r;
    r.kind    = k;
    r.chr     = c;
    r.verdict = v;
    r.last    = 1'b0;
    return r;
  endfunction

  function automatic int entry_index(logic [tdcm_pkg::STATE_W-1:0] st,
                                     logic [tdcm_pkg::CHAR_W-1:0] c);
    return int'(st) * tdcm_pkg::ALPHABET_SIZE + int'(c) - tdcm_pkg::CHAR_BASE;
  endfunction

  // Advance the automaton by one accepted beat and queue the results it causes
  function automatic void step_matcher(in_beat_t b);
    tdcm_pkg::res_t               produced [0:1];
    int                           n;
    logic                         hit;
    logic [tdcm_pkg::STATE_W-1:0] nx;
    n   = 0;
    nx  = '0;
    // 7-bit characters never reach the top of the alphabet; only the low end
    // can miss
    hit = (int'(b.char_code) >= tdcm_pkg::CHAR_BASE);
    case (b.func)
      tdcm_pkg::FUNC_TRANS: begin
        if (hit)
          dfa_next[entry_index(b.state_index, b.char_code)] = b.next_state;
      end
      tdcm_pkg::FUNC_FLAGS: begin
        dfa_flags[b.state_index] = {b.dead_flag, b.final_flag};
      end
      tdcm_pkg::FUNC_MATCH: begin
        if (hit)
          nx = dfa_next[entry_index(shadow_cur, b.char_code)];
        if (reg_mode == tdcm_pkg::MODE_ALL) begin
          // final wins over dead when both are set
          if (hit && dfa_flags[nx][0]) begin
            produced[n] = make_res(tdcm_pkg::KIND_MCHAR, b.char_code, 1'b0);
            n++;
            dfa_open   = 1'b1;
            shadow_cur = nx;
          end else if (!hit || dfa_flags[nx][1]) begin
            shadow_cur = reg_start;
            if (dfa_open) begin
              produced[n] = make_res(tdcm_pkg::KIND_MEND, '0, 1'b0);
              n++;
            end
            dfa_open = 1'b0;
          end else begin
            shadow_cur = nx;
          end
          if (b.end_of_string && dfa_open) begin
            produced[n] = make_res(tdcm_pkg::KIND_MEND, '0, 1'b0);
            n++;
          end
        end else if (reg_mode == tdcm_pkg::MODE_PRE) begin
          // once rejected, stay silent until the string ends
          if (!dfa_rejected) begin
            if (!hit || dfa_flags[nx][1]) begin
              produced[n] = make_res(tdcm_pkg::KIND_VERDICT, '0, 1'b0);
              n++;
              dfa_rejected = 1'b1;
            end else begin
              shadow_cur = nx;
              if (b.end_of_string) begin
                produced[n] = make_res(tdcm_pkg::KIND_VERDICT, '0, dfa_flags[nx][0]);
                n++;
              end
            end
          end
        end else begin
          // full match, and the spare mode code: dead flags play no part
          if (!dfa_rejected) begin
            if (hit)
              shadow_cur = nx;
            else
              dfa_rejected = 1'b1;
          end
          if (b.end_of_string) begin
            produced[n] = make_res(tdcm_pkg::KIND_VERDICT, '0,
                                   !dfa_rejected && dfa_flags[shadow_cur][0]);
            n++;
          end
        end
        if (b.end_of_string) begin
          shadow_cur   = reg_start;
          dfa_open     = 1'b0;
          dfa_rejected = 1'b0;
        end
      end
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      produced[i].last = (i == n - 1);
      expected_results.push_back(produced[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer the oldest pending beat, idling at random
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_ch.ready) begin
      if (drv_valid)
        step_matcher(drv_beat);   // beat accepted at this edge
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_beat  <= pending_beats.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver, counted here and nowhere else
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    tdcm_pkg::res_t want;
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (out_ch.valid && res_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result kind %0d char %0d verdict %0b last %0b",
                   $time, out_ch.kind, out_ch.out_char, out_ch.verdict,
                   out_ch.last_result);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.kind !== want.kind || out_ch.out_char !== want.chr ||
              out_ch.verdict !== want.verdict || out_ch.last_result !== want.last) begin
            mismatches++;
            $display("%0t: result %0d expected kind %0d char %0d verdict %0b last %0b",
                     $time, results_seen, want.kind, want.chr, want.verdict, want.last);
            $display("%0t: result %0d actual   kind %0d char %0d verdict %0b last %0b",
                     $time, results_seen, out_ch.kind, out_ch.out_char,
                     out_ch.verdict, out_ch.last_result);
          end
        end
      end
      res_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Reachable states and alphabet: every (state, character) pair among these
  // is written before any match, and transitions among them stay inside the
  // set, so no unwritten entry is ever read.
  function automatic logic [tdcm_pkg::STATE_W-1:0] live_state(int i);
    case (i)
      0:       return 8'd0;
      1:       return 8'd85;
      2:       return 8'd170;
      default: return 8'd255;
    endcase
  endfunction

  function automatic logic [tdcm_pkg::CHAR_W-1:0] alpha_char(int i);
    case (i)
      0:       return 7'd32;
      1:       return 7'd97;
      2:       return 7'd98;
      default: return 7'd127;
    endcase
  endfunction

  function automatic void queue_beat(logic [tdcm_pkg::FUNC_W-1:0] f,
                                     logic [tdcm_pkg::STATE_W-1:0] s,
                                     logic [tdcm_pkg::CHAR_W-1:0] c,
                                     logic [tdcm_pkg::STATE_W-1:0] nx,
                                     logic fin, logic dead, logic eos);
    in_beat_t b;
    b.func          = f;
    b.state_index   = s;
    b.char_code     = c;
    b.next_state    = nx;
    b.final_flag    = fin;
    b.dead_flag     = dead;
    b.end_of_string = eos;
    pending_beats.push_back(b);
    beats_queued++;
  endfunction

  // Match beat; fields the block does not use carry noise
  function automatic void queue_char(logic [tdcm_pkg::CHAR_W-1:0] c, logic eos);
    queue_beat(tdcm_pkg::FUNC_MATCH, 8'($urandom), c, 8'($urandom), 1'($urandom),
               1'($urandom), eos);
  endfunction

  function automatic void add_random_work();
    int                          roll;
    int                          len;
    logic [tdcm_pkg::CHAR_W-1:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      // a string over the live alphabet, now and then with a stray control
      // character; one in ten is left unterminated
      len = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 12)
          c = 7'($urandom_range(0, tdcm_pkg::CHAR_BASE - 1));
        else
          c = alpha_char($urandom_range(0, 3));
        queue_char(c, (k == len - 1) && ($urandom_range(0, 9) != 0));
      end
    end else if (roll < 77) begin
      queue_beat(tdcm_pkg::FUNC_TRANS, live_state($urandom_range(0, 3)),
                 alpha_char($urandom_range(0, 3)), live_state($urandom_range(0, 3)),
                 1'($urandom), 1'($urandom), 1'($urandom));
    end else if (roll < 85) begin
      queue_beat(tdcm_pkg::FUNC_FLAGS, live_state($urandom_range(0, 3)), 7'($urandom),
                 8'($urandom), 1'($urandom), $urandom_range(0, 3) == 0,
                 1'($urandom));
    end else if (roll < 89) begin
      queue_beat(tdcm_pkg::FUNC_FLAGS, 8'($urandom), 7'($urandom), 8'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom));
    end else if (roll < 92) begin
      // control character: load is dropped
      queue_beat(tdcm_pkg::FUNC_TRANS, 8'($urandom),
                 7'($urandom_range(0, tdcm_pkg::CHAR_BASE - 1)),
                 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end else if (roll < 96) begin
      // state outside the live set: any entry it writes is never read
      queue_beat(tdcm_pkg::FUNC_TRANS, 8'($urandom_range(1, 84)), 7'($urandom),
                 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
    end else begin
      queue_beat(FUNC_NOP, 8'($urandom), 7'($urandom), 8'($urandom),
                 1'($urandom), 1'($urandom), 1'($urandom));
    end
  endfunction

  // Wait until every beat is in and every result is out, then let the
  // pipeline empty of result-free beats
  task automatic settle();
    while (pending_beats.size() != 0 || drv_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [tdcm_pkg::CFG_IDX_W-1:0] idx,
                           logic [tdcm_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_valid <= 1'b0;
    if (idx == tdcm_pkg::CFG_START)
      reg_start = val;
    else
      reg_mode = val[tdcm_pkg::MODE_W-1:0];
    // any register write restarts the string
    shadow_cur   = reg_start;
    dfa_open     = 1'b0;
    dfa_rejected = 1'b0;
  endtask

  task automatic set_regs(logic [tdcm_pkg::MODE_W-1:0] mode,
                          logic [tdcm_pkg::STATE_W-1:0] st);
    if ($urandom_range(0, 1) != 0) begin
      write_reg(tdcm_pkg::CFG_START, st);
      write_reg(tdcm_pkg::CFG_MODE, {6'($urandom), mode});
    end else begin
      write_reg(tdcm_pkg::CFG_MODE, {6'($urandom), mode});
      write_reg(tdcm_pkg::CFG_START, st);
    end
  endtask

  initial begin : stimulus
    logic [tdcm_pkg::MODE_W-1:0]  mode;
    logic [tdcm_pkg::STATE_W-1:0] st;
    int                           first;
    for (int i = 0; i < tdcm_pkg::MAX_STATES; i++)
      dfa_flags[i] = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Build the automaton: a rotating transition pattern over the live set,
    // flags plain, final, dead, and final-and-dead in turn
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        queue_beat(tdcm_pkg::FUNC_TRANS, live_state(i), alpha_char(j),
                   live_state((i + j + 1) % 4), 1'($urandom), 1'($urandom),
                   1'($urandom));
    for (int i = 0; i < 4; i++)
      queue_beat(tdcm_pkg::FUNC_FLAGS, live_state(i), 7'($urandom), 8'($urandom),
                 i[0], i[1], 1'($urandom));

    // Full match with reset registers: accept, reject, control characters,
    // unused function, dropped load, and a string left open for the restart
    queue_char(7'd32, 1'b1);
    queue_char(7'd97, 1'b0);
    queue_char(7'd127, 1'b1);
    queue_char(7'd0, 1'b0);
    queue_char(7'd32, 1'b1);
    queue_char(7'd31, 1'b1);
    queue_beat(FUNC_NOP, 8'hFF, 7'h7F, 8'hFF, 1'b1, 1'b1, 1'b1);
    queue_beat(tdcm_pkg::FUNC_TRANS, 8'd255, 7'd5, 8'd0, 1'b0, 1'b0, 1'b0);
    queue_char(7'd127, 1'b0);
    settle();

    // Preemptive: early rejection with trailing characters, an accept, then a rejection
    write_reg(tdcm_pkg::CFG_MODE, {6'd0, tdcm_pkg::MODE_PRE});
    queue_char(7'd97, 1'b0);
    queue_char(7'd32, 1'b0);
    queue_char(7'd98, 1'b1);
    queue_char(7'd32, 1'b1);
    queue_char(7'd98, 1'b0);
    queue_char(7'd127, 1'b1);
    settle();

    // Match all: two results on one beat, match end on a dead state,
    // control character at string end
    write_reg(tdcm_pkg::CFG_MODE, {6'd0, tdcm_pkg::MODE_ALL});
    queue_char(7'd32, 1'b0);
    queue_char(7'd97, 1'b1);
    queue_char(7'd98, 1'b0);
    queue_char(7'd32, 1'b0);
    queue_char(7'd97, 1'b0);
    queue_char(7'd0, 1'b1);
    queue_char(7'd127, 1'b1);
    settle();

    // Random phases: each with its own registers and idle/stall pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          mode = tdcm_pkg::MODE_ALL;  st = 8'd0;   send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          mode = tdcm_pkg::MODE_PRE;  st = 8'd255; send_idle_pct = 60; recv_stall_pct = 0;
        end
        2: begin
          mode = tdcm_pkg::MODE_FULL; st = 8'd85;  send_idle_pct = 0;  recv_stall_pct = 0;
        end
        3: begin
          mode = MODE_FULL_ALIAS;     st = 8'd170; send_idle_pct = 0;  recv_stall_pct = 60;
        end
        4: begin
          mode = tdcm_pkg::MODE_ALL;  st = 8'd255; send_idle_pct = 6;  recv_stall_pct = 6;
        end
        5: begin
          mode = tdcm_pkg::MODE_PRE;  st = 8'd0;   send_idle_pct = 0;  recv_stall_pct = 60;
        end
        6: begin
          mode = tdcm_pkg::MODE_ALL;
          st   = live_state($urandom_range(0, 3));
          send_idle_pct  = 60;
          recv_stall_pct = 0;
        end
        7: begin
          mode = tdcm_pkg::MODE_FULL; st = 8'd255; send_idle_pct = 6;  recv_stall_pct = 6;
        end
        default: begin
          mode = tdcm_pkg::MODE_PRE;
          st   = 8'd170;
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      set_regs(mode, st);
      // hold the receiver off while the sender keeps offering: the result
      // buffer and the command queue fill and the input stalls
      if (p == 2)
        hold_req = 1'b1;
      first = beats_queued;
      while (beats_queued - first < BEATS_PER_PHASE)
        add_random_work();
      settle();
    end

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Run limit, far beyond the slowest correct run
  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

endmodule
